// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the loss scaler core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// dls_pkg
// Types, constants and binary32 helpers shared by the loss scaler core.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int unsigned DLS_QDEPTH = 2;

  localparam logic [31:0] FP_CANON_NAN  = 32'h7FC0_0000;
  localparam logic [30:0] FP_INF_MAG    = 31'h7F80_0000;
  localparam logic [31:0] FP_TWO        = 32'h4000_0000;
  localparam logic [31:0] FP_HALF       = 32'h3F00_0000;
  localparam logic [31:0] SCALE_RST     = 32'h4780_0000;
  localparam logic [31:0] RECIP_RST     = 32'h3780_0000;
  localparam logic [15:0] INTERVAL_RST  = 16'd2000;

  // command codes on the input port
  localparam logic [1:0] CMD_SCALE   = 2'd0;
  localparam logic [1:0] CMD_UNSCALE = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_SCALE    = 1'b0;
  localparam logic CFG_IDX_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_UNSCALE,
    OP_UPDATE,
    OP_NONE
  } dls_op_t;

  typedef struct packed {
    dls_op_t     op;
    logic [31:0] value;
    logic        last;
    logic        skipped;
  } dls_item_t;

  // unpacked operand, mantissa normalized so bit 23 is set
  typedef struct packed {
    logic              sgn;
    logic              nan;
    logic              inf;
    logic              zero;
    logic signed [9:0] e;
    logic [23:0]       m;
  } dls_unp_t;

  function automatic logic [4:0] dls_lzc24(input logic [23:0] m);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  function automatic dls_unp_t dls_unpack(input logic [31:0] x);
    dls_unp_t   u;
    logic [7:0] e8;
    logic [23:0] m;
    logic [4:0] lz;
    e8     = x[30:23];
    m      = {e8 != 8'd0, x[22:0]};
    lz     = dls_lzc24(m);
    u.sgn  = x[31];
    u.nan  = (e8 == 8'hFF) && (x[22:0] != 23'd0);
    u.inf  = (e8 == 8'hFF) && (x[22:0] == 23'd0);
    u.zero = (e8 == 8'd0) && (x[22:0] == 23'd0);
    u.m    = m << lz;
    u.e    = ((e8 == 8'd0) ? 10'sd1 : $signed({2'b00, e8})) - $signed({5'd0, lz});
    return u;
  endfunction

  // m has its lead bit at 47, e is the biased exponent of that bit.
  // Round to nearest even, with gradual underflow and overflow to inf.
  function automatic logic [31:0] dls_round_pack(input logic sgn,
                                                 input logic signed [10:0] e,
                                                 input logic [47:0] m,
                                                 input logic stk_in);
    logic signed [10:0] ne;
    logic [5:0]  sh;
    logic [47:0] mask;
    logic [47:0] mx;
    logic        stk;
    logic [7:0]  expf;
    logic        inc;
    logic [30:0] mag;
    ne   = 11'sd1 - e;
    sh   = (e > 11'sd0) ? 6'd0 : ((ne > 11'sd63) ? 6'd63 : ne[5:0]);
    mask = ~({48{1'b1}} << sh);
    mx   = m >> sh;
    stk  = stk_in | (|(m & mask)) | (|mx[22:0]);
    expf = (e > 11'sd0) ? e[7:0] : 8'd0;
    inc  = mx[23] & (stk | mx[24]);
    mag  = {expf, mx[46:24]} + {30'd0, inc};
    if (e >= 11'sd255) mag = FP_INF_MAG;
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] dls_canon(input logic [31:0] x);
    return ((x[30:23] == 8'hFF) && (x[22:0] != 23'd0)) ? FP_CANON_NAN : x;
  endfunction

endpackage

// ===== rtl/core/dls_fmul.sv =====
// ----------------------------------------------------------------------------
// dls_fmul
// Three-stage binary32 multiplier: unpack/normalize, 24x24 product, round.
// ----------------------------------------------------------------------------
module dls_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        valid,
  output logic [31:0] y
);
  import dls_pkg::*;

  dls_unp_t ua, ub;

  logic              a_vld_r, a_sgn_r, a_nan_r, a_inf_r, a_zero_r;
  logic signed [9:0] a_ea_r, a_eb_r;
  logic [23:0]       a_ma_r, a_mb_r;

  logic               b_vld_r, b_sgn_r, b_nan_r, b_inf_r, b_zero_r;
  logic signed [10:0] b_e_r;
  logic [47:0]        b_p_r;

  logic               c_vld_r;
  logic [31:0]        c_y_r;

  logic signed [10:0] c_e;
  logic [47:0]        c_m;
  logic [31:0]        c_y;

  assign ua = dls_unpack(a);
  assign ub = dls_unpack(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_sgn_r  <= ua.sgn ^ ub.sgn;
    a_nan_r  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    a_inf_r  <= ua.inf | ub.inf;
    a_zero_r <= ua.zero | ub.zero;
    a_ea_r   <= ua.e;
    a_eb_r   <= ub.e;
    a_ma_r   <= ua.m;
    a_mb_r   <= ub.m;

    b_sgn_r  <= a_sgn_r;
    b_nan_r  <= a_nan_r;
    b_inf_r  <= a_inf_r;
    b_zero_r <= a_zero_r;
    b_p_r    <= a_ma_r * a_mb_r;
    b_e_r    <= 11'(a_ea_r) + 11'(a_eb_r) - 11'sd127;

    c_y_r    <= c_y;
  end

  always_comb begin
    if (b_p_r[47]) begin
      c_m = b_p_r;
      c_e = b_e_r + 11'sd1;
    end else begin
      c_m = b_p_r << 1;
      c_e = b_e_r;
    end
    if (b_nan_r)       c_y = FP_CANON_NAN;
    else if (b_inf_r)  c_y = {b_sgn_r, FP_INF_MAG};
    else if (b_zero_r) c_y = {b_sgn_r, 31'd0};
    else               c_y = dls_round_pack(b_sgn_r, c_e, c_m, 1'b0);
  end

  assign valid = c_vld_r;
  assign y     = c_y_r;

endmodule

// ===== rtl/core/dls_frecip.sv =====
// ----------------------------------------------------------------------------
// dls_frecip
// Binary32 reciprocal by restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dls_frecip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] x,
  output logic        done,
  output logic [31:0] y
);
  import dls_pkg::*;

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_DIV  = 3'b010,
    RS_FIN  = 3'b100
  } rcp_st_t;

  localparam logic [4:0] QBITS_M1 = 5'd26;

  rcp_st_t           state_r, state_nxt;
  dls_unp_t          ux;
  logic              sgn_r, spec_r;
  logic [31:0]       spec_y_r;
  logic signed [9:0] e_r;
  logic [23:0]       m_r;
  logic [24:0]       rem_r;
  logic [26:0]       q_r;
  logic [4:0]        cnt_r;

  logic              qbit;
  logic [24:0]       rem_sub;
  logic signed [10:0] f_e;
  logic [47:0]       f_m;

  assign ux      = dls_unpack(x);
  assign qbit    = rem_r >= {1'b0, m_r};
  assign rem_sub = qbit ? (rem_r - {1'b0, m_r}) : rem_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RS_IDLE: state_nxt = RS_IDLE;
      RS_DIV:  if (cnt_r == 5'd0) state_nxt = RS_FIN;
      RS_FIN:  state_nxt = RS_IDLE;
      default: state_nxt = RS_IDLE;
    endcase
    if (start) begin
      state_nxt = (ux.nan || ux.inf || ux.zero) ? RS_FIN : RS_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= RS_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sgn_r  <= ux.sgn;
      spec_r <= ux.nan | ux.inf | ux.zero;
      if (ux.nan)       spec_y_r <= FP_CANON_NAN;
      else if (ux.zero) spec_y_r <= {ux.sgn, FP_INF_MAG};
      else              spec_y_r <= {ux.sgn, 31'd0};
      e_r   <= ux.e;
      m_r   <= ux.m;
      rem_r <= 25'h080_0000;
      q_r   <= 27'd0;
      cnt_r <= QBITS_M1;
    end else if (state_r == RS_DIV) begin
      rem_r <= {rem_sub[23:0], 1'b0};
      q_r   <= {q_r[25:0], qbit};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  // 1/x = (2^49/m) * 2^-26 * 2^(127-e)
  always_comb begin
    if (q_r[26]) begin
      f_m = {1'b1, 47'd0};
      f_e = 11'sd254 - 11'(e_r);
    end else begin
      f_m = {q_r[25:0], 22'd0};
      f_e = 11'sd253 - 11'(e_r);
    end
  end

  assign done = (state_r == RS_FIN);
  assign y    = spec_r ? spec_y_r : dls_round_pack(sgn_r, f_e, f_m, rem_r != 25'd0);

endmodule

// ===== rtl/core/dls_front.sv =====
// ----------------------------------------------------------------------------
// dls_front
// Accepts items, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dls_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [31:0]       value_in,
  input  logic              last_element,
  input  logic              skipped,
  output logic              q_nempty,
  output dls_pkg::dls_item_t q_item,
  input  logic              q_pop
);
  import dls_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  dls_item_t         slot_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              push_ok;
  dls_item_t         new_item;

  always_comb begin
    new_item.value   = value_in;
    new_item.last    = last_element;
    new_item.skipped = skipped;
    case (cmd)
      CMD_SCALE:   new_item.op = OP_SCALE;
      CMD_UNSCALE: new_item.op = OP_UNSCALE;
      CMD_UPDATE:  new_item.op = OP_UPDATE;
      default:     new_item.op = OP_NONE;
    endcase
  end

  assign full     = (count_r == CW'(QDEPTH));
  assign push_ok  = push && !full;
  assign q_nempty = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) slot_r[wr_ptr_r] <= new_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !q_pop)      count_r <= count_r + 1'b1;
      else if (!push_ok && q_pop) count_r <= count_r - 1'b1;
    end
  end

  `DLS_ASSERT_NOW(a_pop_nonempty, q_pop, count_r != '0, "queue read while empty")
  `DLS_ASSERT_NEXT(a_fill_count, push_ok && !q_pop, count_r == CW'($past(count_r) + 1'b1), "lost item")
  `DLS_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(QDEPTH), "queue count past depth")

endmodule

// ===== rtl/core/dls_back.sv =====
// ----------------------------------------------------------------------------
// dls_back
// Executes queued items: scale state, multiplier, reciprocal, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dls_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nempty,
  input  dls_pkg::dls_item_t q_item,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        value_out,
  output logic               overflow_seen,
  output logic [15:0]        good_steps,
  output logic [31:0]        current_scale
);
  import dls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_RCP  = 3'b100
  } back_st_t;

  back_st_t    state_r, state_nxt;
  logic [31:0] scale_r, scale_nxt;
  logic [31:0] recip_r, recip_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        sticky_r, sticky_nxt;
  logic [15:0] interval_r;
  dls_op_t     op_r;
  logic        last_r;

  logic        out_valid_r;
  logic [31:0] out_value_r, out_scale_r;
  logic        out_flag_r;
  logic [15:0] out_cnt_r;

  logic        out_load;
  logic [31:0] ld_value;
  logic        ld_flag;

  logic        mul_start, mul_valid;
  logic [31:0] mul_a, mul_b, mul_y;
  logic        rcp_start, rcp_done;
  logic [31:0] rcp_x, rcp_y;
  logic [15:0] cnt_inc;
  logic        unscale_flag;

  dls_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .valid (mul_valid),
    .y     (mul_y)
  );

  dls_frecip u_frecip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rcp_start),
    .x     (rcp_x),
    .done  (rcp_done),
    .y     (rcp_y)
  );

  assign cnt_inc      = cnt_r + 16'd1;
  assign unscale_flag = sticky_r | (mul_y[30:23] == 8'hFF);

  always_comb begin
    state_nxt  = state_r;
    scale_nxt  = scale_r;
    recip_nxt  = recip_r;
    cnt_nxt    = cnt_r;
    sticky_nxt = sticky_r;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    mul_a      = q_item.value;
    mul_b      = scale_r;
    rcp_start  = 1'b0;
    rcp_x      = mul_y;
    out_load   = 1'b0;
    ld_value   = 32'd0;
    ld_flag    = sticky_r;

    case (state_r)
      ST_IDLE: begin
        if (q_nempty && !out_valid_r) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_SCALE: begin
              mul_start = 1'b1;
              state_nxt = ST_MUL;
            end
            OP_UNSCALE: begin
              mul_b     = recip_r;
              mul_start = 1'b1;
              state_nxt = ST_MUL;
            end
            OP_UPDATE: begin
              mul_a = scale_r;
              if (q_item.skipped) begin
                mul_b     = FP_HALF;
                mul_start = 1'b1;
                cnt_nxt   = 16'd0;
                state_nxt = ST_MUL;
              end else if (cnt_inc == interval_r) begin
                mul_b     = FP_TWO;
                mul_start = 1'b1;
                cnt_nxt   = 16'd0;
                state_nxt = ST_MUL;
              end else begin
                // scale unchanged, so the reciprocal stands
                cnt_nxt  = cnt_inc;
                out_load = 1'b1;
                ld_value = dls_canon(scale_r);
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_valid) begin
          out_load  = 1'b1;
          ld_value  = mul_y;
          state_nxt = ST_IDLE;
          case (op_r)
            OP_UNSCALE: begin
              ld_flag    = unscale_flag;
              sticky_nxt = last_r ? 1'b0 : unscale_flag;
            end
            OP_UPDATE: begin
              scale_nxt = mul_y;
              rcp_start = 1'b1;
              state_nxt = ST_RCP;
            end
            default: ;
          endcase
        end
      end
      ST_RCP: begin
        if (rcp_done) begin
          recip_nxt = rcp_y;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // initial scale reload; user writes only while block is quiet, unchecked
    if (cfg_we && (cfg_index == CFG_IDX_SCALE)) begin
      scale_nxt = cfg_wdata;
      cnt_nxt   = 16'd0;
      rcp_x     = cfg_wdata;
      rcp_start = 1'b1;
      state_nxt = ST_RCP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= SCALE_RST;
      recip_r     <= RECIP_RST;
      cnt_r       <= 16'd0;
      sticky_r    <= 1'b0;
      interval_r  <= INTERVAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scale_r  <= scale_nxt;
      recip_r  <= recip_nxt;
      cnt_r    <= cnt_nxt;
      sticky_r <= sticky_nxt;
      if (cfg_we && (cfg_index == CFG_IDX_INTERVAL)) interval_r <= cfg_wdata[15:0];
      if (out_load)                out_valid_r <= 1'b1;
      else if (pop && out_valid_r) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r   <= q_item.op;
      last_r <= q_item.last;
    end
    if (out_load) begin
      out_value_r <= ld_value;
      out_flag_r  <= ld_flag;
      out_cnt_r   <= cnt_nxt;
      out_scale_r <= dls_canon(scale_nxt);
    end
  end

  assign empty         = !out_valid_r;
  assign value_out     = out_value_r;
  assign overflow_seen = out_flag_r;
  assign good_steps    = out_cnt_r;
  assign current_scale = out_scale_r;

  `DLS_ASSERT_NOW(a_load_free, out_load, !out_valid_r, "result register overwritten")
  `DLS_ASSERT_NOW(a_pop_idle, q_pop, state_r == ST_IDLE, "item taken while busy")
  `DLS_ASSERT_NOW(a_mul_expected, mul_valid, state_r == ST_MUL, "stray product")

endmodule

// ===== rtl/core/dynamic_loss_scaler.sv =====
// ----------------------------------------------------------------------------
// dynamic_loss_scaler
// Dynamic loss scaling for mixed-precision training, binary32 datapath.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  input    | push / full       | in_cmd, in_value_in, in_last_element,
//           |                   | in_skipped
//  result   | empty / pop       | out_value_out, out_overflow_seen,
//           |                   | out_good_steps, out_current_scale
//  config   | cfg_we            | cfg_index, cfg_wdata
//
//  Scale-loss, unscale and scale-changing update go through the three-stage
//  multiplier; cmd 3 and a count-only update load the result directly. One
//  item in the back end at a time; the next waits until the result is
//  popped and any reciprocal work is done. A scale change starts reciprocal
//  work; so does an initial-scale write, and items queue meanwhile.
//  Reset (rst_n low, synchronous) loads scale 65536.0, interval 2000.
// ----------------------------------------------------------------------------
module dynamic_loss_scaler #(
  parameter int unsigned QDEPTH = dls_pkg::DLS_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_value_in,
  input  logic        in_last_element,
  input  logic        in_skipped,
  // result register side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_value_out,
  output logic        out_overflow_seen,
  output logic [15:0] out_good_steps,
  output logic [31:0] out_current_scale,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import dls_pkg::*;

  logic      q_nempty;
  logic      q_pop;
  dls_item_t q_item;

  // front: decode and buffer, so the source keeps streaming while the
  // back end waits on the multiplier, reciprocal or a stalled result
  dls_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .cmd          (in_cmd),
    .value_in     (in_value_in),
    .last_element (in_last_element),
    .skipped      (in_skipped),
    .q_nempty     (q_nempty),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: scale/reciprocal/counter/sticky state and the arithmetic;
  // a stalled result holds in its output register
  dls_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nempty      (q_nempty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .empty         (empty),
    .pop           (pop),
    .value_out     (out_value_out),
    .overflow_seen (out_overflow_seen),
    .good_steps    (out_good_steps),
    .current_scale (out_current_scale)
  );

endmodule

// ===== verif/tb_dynamic_loss_scaler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dynamic_loss_scaler
// Self-checking bench for the dynamic loss scaler. A binary32 predictor with
// its own multiply, reciprocal and RNE rounding tracks scale, reciprocal,
// good-step count and the sticky overflow flag; every result is compared with
// the oldest prediction. Directed corner items come first, then phases of
// random tensors and updates under several register settings.
// ----------------------------------------------------------------------------
module tb_dynamic_loss_scaler;
  import dls_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unknown command, changes nothing

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic        last;
    logic        skip;
  } item_t;

  typedef struct {
    logic [31:0] value;
    logic        flag;
    logic [15:0] steps;
    logic [31:0] scale;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_cmd;
  logic [31:0] in_value_in;
  logic        in_last_element;
  logic        in_skipped;
  logic        empty;
  logic        pop;
  logic [31:0] out_value_out;
  logic        out_overflow_seen;
  logic [15:0] out_good_steps;
  logic [31:0] out_current_scale;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  dynamic_loss_scaler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_cmd           (in_cmd),
    .in_value_in      (in_value_in),
    .in_last_element  (in_last_element),
    .in_skipped       (in_skipped),
    .empty            (empty),
    .pop              (pop),
    .out_value_out    (out_value_out),
    .out_overflow_seen(out_overflow_seen),
    .out_good_steps   (out_good_steps),
    .out_current_scale(out_current_scale),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [31:0] scale_m;
  logic [31:0] recip_m;
  logic [15:0] steps_m;
  logic        sticky_m;
  logic [15:0] interval_m;

  item_t   pending_items[$];
  result_t predicted_results[$];
  int      errors;
  bit      calm;       // no random idling on either side
  bit      sent;       // item on the input ports has been taken
  int      hold_reqs;  // long receiver holds asked for
  int      hold_done;
  int      hold_left;

  // --------------------------------------------------------------------------
  // binary32 arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic [31:0] canon(logic [31:0] x);
    return is_nan(x) ? FP_CANON_NAN : x;
  endfunction

  // Finite nonzero operand: normalized 24-bit mantissa, biased exponent
  // (can go below 1 for subnormals).
  function automatic void split(input logic [31:0] x, output int e,
                                output logic [23:0] m);
    if (x[30:23] == 8'd0) begin
      m = {1'b0, x[22:0]};
      e = 1;
      while (!m[23]) begin
        m = m << 1;
        e--;
      end
    end else begin
      m = {1'b1, x[22:0]};
      e = int'(x[30:23]);
    end
  endfunction

  // m: lead bit at 47 (or below when the value is tiny), e: biased exponent
  // of bit 47. Round to nearest even with gradual underflow.
  function automatic logic [31:0] pack_rne(logic sgn, int e, logic [47:0] m,
                                           logic stk);
    int          sh;
    logic [47:0] mx;
    logic        st;
    logic        inc;
    logic [7:0]  expf;
    logic [30:0] mag;
    if (e >= 255) return {sgn, FP_INF_MAG};
    sh   = (e > 0) ? 0 : 1 - e;
    if (sh > 48) sh = 48;
    mx   = m >> sh;
    st   = stk || ((m & ~({48{1'b1}} << sh)) != 0) || (mx[22:0] != 0);
    inc  = mx[23] & (st | mx[24]);
    expf = (e > 0) ? 8'(e) : 8'd0;
    mag  = {expf, mx[46:24]} + 31'(inc);
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    int          ea;
    int          eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    bit          a_inf;
    bit          b_inf;
    bit          a_zero;
    bit          b_zero;
    sgn    = a[31] ^ b[31];
    a_inf  = a[30:0] == FP_INF_MAG;
    b_inf  = b[30:0] == FP_INF_MAG;
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    if (is_nan(a) || is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero))
      return FP_CANON_NAN;
    if (a_inf || b_inf) return {sgn, FP_INF_MAG};
    if (a_zero || b_zero) return {sgn, 31'd0};
    split(a, ea, ma);
    split(b, eb, mb);
    p = ma * mb;
    if (p[47]) return pack_rne(sgn, ea + eb - 126, p, 1'b0);
    return pack_rne(sgn, ea + eb - 127, p << 1, 1'b0);
  endfunction

  function automatic logic [31:0] fp_recip(logic [31:0] s);
    int          es;
    logic [23:0] ms;
    logic [71:0] q;
    logic [71:0] r;
    if (s[30:0] == 0) return {s[31], FP_INF_MAG};  // signed zero -> signed inf
    if (is_nan(s)) return FP_CANON_NAN;
    if (s[30:0] == FP_INF_MAG) return {s[31], 31'd0};
    split(s, es, ms);
    if (ms == 24'h80_0000) return pack_rne(s[31], 254 - es, 48'h8000_0000_0000, 1'b0);
    q = (72'd1 << 71) / ms;
    r = (72'd1 << 71) % ms;
    return pack_rne(s[31], 253 - es, q[47:0], r != 0);
  endfunction

  function automatic void load_scale(logic [31:0] bits);
    scale_m = bits;
    recip_m = fp_recip(bits);
    steps_m = 16'd0;
  endfunction

  // one accepted item -> expected result, state advanced
  function automatic void scaler_step(item_t it);
    result_t     res;
    logic [31:0] g;
    res.value = 32'd0;
    res.flag  = sticky_m;
    case (it.cmd)
      CMD_SCALE: res.value = canon(fp_mul(it.value, scale_m));
      CMD_UNSCALE: begin
        g         = fp_mul(it.value, recip_m);
        res.flag  = sticky_m || (g[30:23] == 8'hFF);
        sticky_m  = it.last ? 1'b0 : res.flag;
        res.value = canon(g);
      end
      CMD_UPDATE: begin
        if (it.skip) begin
          scale_m = fp_mul(scale_m, FP_HALF);
          steps_m = 16'd0;
        end else begin
          steps_m = steps_m + 16'd1;  // wraps at 16 bits
          if (steps_m == interval_m) begin
            scale_m = fp_mul(scale_m, FP_TWO);
            steps_m = 16'd0;
          end
        end
        recip_m   = fp_recip(scale_m);
        res.value = canon(scale_m);
      end
      default: ;
    endcase
    res.steps = steps_m;
    res.scale = canon(scale_m);
    predicted_results.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // driver: predicts on acceptance, drives on the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      scaler_step('{in_cmd, in_value_in, in_last_element, in_skipped});
      sent = 1'b1;
    end
  end

  always @(negedge clk) begin
    item_t it;
    if (rst_n && !(push && !sent)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        it = pending_items.pop_front();
        push            <= 1'b1;
        in_cmd          <= it.cmd;
        in_value_in     <= it.value;
        in_last_element <= it.last;
        in_skipped      <= it.skip;
        sent = 1'b0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks on the rising edge, pop decided on the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t e;
    if (rst_n && pop && !empty) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result value=%h flag=%b steps=%0d scale=%h", $time,
                 out_value_out, out_overflow_seen, out_good_steps, out_current_scale);
        errors++;
      end else begin
        e = predicted_results.pop_front();
        if (out_value_out !== e.value) begin
          $display("%0t: value_out exp %h got %h", $time, e.value, out_value_out);
          errors++;
        end
        if (out_overflow_seen !== e.flag) begin
          $display("%0t: overflow_seen exp %b got %b", $time, e.flag, out_overflow_seen);
          errors++;
        end
        if (out_good_steps !== e.steps) begin
          $display("%0t: good_steps exp %0d got %0d", $time, e.steps, out_good_steps);
          errors++;
        end
        if (out_current_scale !== e.scale) begin
          $display("%0t: current_scale exp %h got %h", $time, e.scale, out_current_scale);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_done < hold_reqs && hold_left == 0) begin
      hold_done++;
      hold_left = 300;  // long hold so the queue fills and full rises
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && (calm || $urandom_range(99) >= 10);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'd0;                           // subnormal or zero
      1: v[30:23] = 8'(254 - $urandom_range(3));    // near overflow
      2: v[30:23] = 8'hFF;                          // inf or NaN
      3: v[22:0] = ($urandom_range(3) == 0) ? 23'd0 : v[22:0];
      default: v[30:23] = 8'(127 + $urandom_range(60) - 30);
    endcase
    return v;
  endfunction

  task automatic add_item(logic [1:0] c, logic [31:0] v, logic l, logic s);
    item_t it;
    it.cmd   = c;
    it.value = v;
    it.last  = l;
    it.skip  = s;
    pending_items.push_back(it);
  endtask

  // sender stops until every predicted result has come, then the pipeline
  // is given time to finish any reciprocal work
  task automatic drain();
    while (pending_items.size() != 0 || (push && !sent) || predicted_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_IDX_SCALE) load_scale(data);
    else interval_m = data[15:0];
  endtask

  // random tensors of unscale items mixed with scale-loss, updates and unknown commands
  task automatic random_phase(int n);
    int k;
    int len;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 8);
          for (int j = 0; j < len; j++)
            add_item(CMD_UNSCALE, rand_fp(), j == len - 1, 1'($urandom_range(1)));
          k += len;
        end
        5, 6: begin
          add_item(CMD_SCALE, rand_fp(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          k++;
        end
        7, 8: begin
          add_item(CMD_UPDATE, $urandom, 1'($urandom_range(1)), $urandom_range(4) == 0);
          k++;
        end
        default: begin
          add_item($urandom_range(9) == 0 ? CMD_NONE : CMD_UNSCALE, rand_fp(),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    push            = 1'b0;
    in_cmd          = CMD_SCALE;
    in_value_in     = 32'd0;
    in_last_element = 1'b0;
    in_skipped      = 1'b0;
    pop             = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_IDX_SCALE;
    cfg_wdata       = 32'd0;
    errors          = 0;
    calm            = 1'b0;
    sent            = 1'b1;
    hold_reqs       = 0;
    hold_done       = 0;
    hold_left       = 0;
    interval_m      = INTERVAL_RST;
    sticky_m        = 1'b0;
    load_scale(SCALE_RST);
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners at reset settings
    add_item(CMD_SCALE, 32'h3F80_0000, 1'b0, 1'b0);
    add_item(CMD_SCALE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_item(CMD_SCALE, 32'h7F7F_FFFF, 1'b0, 1'b0);   // overflows to inf
    add_item(CMD_SCALE, 32'h0000_0001, 1'b0, 1'b0);
    add_item(CMD_SCALE, 32'h8000_0000, 1'b0, 1'b0);
    add_item(CMD_UNSCALE, 32'h0000_0001, 1'b0, 1'b0); // underflows to zero
    add_item(CMD_UNSCALE, 32'h7F80_0000, 1'b0, 1'b0); // sets the sticky flag
    add_item(CMD_UNSCALE, 32'h3F80_0000, 1'b0, 1'b0); // flag stays
    add_item(CMD_SCALE, 32'h4000_0000, 1'b0, 1'b0);   // reports flag, keeps it
    add_item(CMD_UNSCALE, 32'h4000_0000, 1'b1, 1'b0); // last: reports, then clears
    add_item(CMD_UNSCALE, 32'h4000_0000, 1'b0, 1'b0);
    add_item(CMD_UNSCALE, 32'h7FC0_1234, 1'b1, 1'b0); // NaN on last element
    add_item(CMD_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1);    // unknown command
    add_item(CMD_UPDATE, 32'd0, 1'b0, 1'b1);          // halve
    add_item(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0);  // good step
    add_item(CMD_UPDATE, 32'd0, 1'b0, 1'b0);
    add_item(CMD_UNSCALE, 32'h807F_FFFF, 1'b1, 1'b0);
    random_phase(60);

    // growth every step, scale 1.0; long receiver hold while sending
    write_reg(CFG_IDX_SCALE, 32'h3F80_0000);
    write_reg(CFG_IDX_INTERVAL, 32'd1);
    hold_reqs++;
    random_phase(90);

    // largest finite scale and largest interval, no idling
    write_reg(CFG_IDX_SCALE, 32'h7F7F_FFFF);
    write_reg(CFG_IDX_INTERVAL, 32'd65535);
    calm = 1'b1;
    random_phase(90);
    calm = 1'b0;

    // smallest subnormal scale: reciprocal overflows
    write_reg(CFG_IDX_SCALE, 32'h0000_0001);
    write_reg(CFG_IDX_INTERVAL, 32'd3);
    for (int j = 0; j < 6; j++) add_item(CMD_UPDATE, 32'd0, 1'b0, 1'b0);
    random_phase(80);

    // zero scales give signed infinite reciprocals
    write_reg(CFG_IDX_SCALE, 32'h0000_0000);
    write_reg(CFG_IDX_INTERVAL, 32'd2);
    random_phase(40);
    write_reg(CFG_IDX_SCALE, 32'h8000_0000);
    random_phase(40);

    // NaN scale propagates; interval 0 only matches after the count wraps
    write_reg(CFG_IDX_SCALE, 32'hFFC0_0001);
    write_reg(CFG_IDX_INTERVAL, 32'd0);
    random_phase(60);

    // infinite scale, then interval lowered below the running count
    write_reg(CFG_IDX_SCALE, 32'h7F80_0000);
    write_reg(CFG_IDX_INTERVAL, 32'd4);
    random_phase(40);
    write_reg(CFG_IDX_SCALE, 32'h4780_0000);
    write_reg(CFG_IDX_INTERVAL, 32'd50);
    for (int j = 0; j < 10; j++) add_item(CMD_UPDATE, 32'd0, 1'b0, 1'b0);
    write_reg(CFG_IDX_INTERVAL, 32'd5);
    random_phase(60);

    // random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_IDX_SCALE, rand_fp());
      write_reg(CFG_IDX_INTERVAL, {16'd0, 16'($urandom_range(1, 6))});
      random_phase(60);
    end

    drain();
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dls_pkg.sv
rtl/core/dls_fmul.sv
rtl/core/dls_frecip.sv
rtl/core/dls_front.sv
rtl/core/dls_back.sv
rtl/core/dynamic_loss_scaler.sv
verif/tb_dynamic_loss_scaler.sv
